// File: hw/rtl/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg
// Types and constants shared by the motor command text parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcp_pkg;

  localparam int unsigned SpeedW = 14;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumIntDigits = 3;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiColon = 8'h3a;
  localparam logic [7:0] AsciiDot = 8'h2e;

  localparam logic [SpeedW-1:0] SpeedReset = 14'd110;
  localparam logic [SpeedW-1:0] Weight1000 = 14'd1000;
  localparam logic [SpeedW-1:0] Weight100 = 14'd100;
  localparam logic [SpeedW-1:0] Weight10 = 14'd10;

  localparam int unsigned NumStates = 23;

  typedef enum logic [NumStates-1:0] {
    ST_IDLE  = 23'h000001,
    ST_D1    = 23'h000002,
    ST_D2    = 23'h000004,
    ST_D3    = 23'h000008,
    ST_D4    = 23'h000010,
    ST_DC1   = 23'h000020,
    ST_DC2   = 23'h000040,
    ST_M1    = 23'h000080,
    ST_M2    = 23'h000100,
    ST_M3    = 23'h000200,
    ST_M4    = 23'h000400,
    ST_M5    = 23'h000800,
    ST_MO    = 23'h001000,
    ST_MF    = 23'h002000,
    ST_MFF   = 23'h004000,
    ST_R1    = 23'h008000,
    ST_R2    = 23'h010000,
    ST_R3    = 23'h020000,
    ST_RD0   = 23'h040000,
    ST_RD1   = 23'h080000,
    ST_RD2   = 23'h100000,
    ST_RDOT  = 23'h200000,
    ST_RFRAC = 23'h400000
  } parse_state_e;

  typedef struct packed {
    logic [SpeedW-1:0] speed_tenths;
    logic              motor_on;
    logic              direction;
  } mcp_result_t;

endpackage

// File: hw/rtl/mcp_parser.sv
// ----------------------------------------------------------------------------
// mcp_parser
// Byte-wise command recogniser holding direction, motor flag and speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcp_parser
  import mcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  rx_byte_i,
  output mcp_result_t result_o
);

  parse_state_e state_q, state_d;
  logic [DigitW-1:0] digits_q [NumIntDigits];
  logic [DigitW-1:0] digits_d [NumIntDigits];
  logic direction_q, direction_d;
  logic motor_on_q, motor_on_d;
  logic [SpeedW-1:0] speed_q, speed_d;

  logic              is_digit;
  logic [DigitW-1:0] digit_val;
  logic [SpeedW-1:0] speed_calc;

  assign is_digit = (rx_byte_i >= AsciiZero) && (rx_byte_i <= AsciiNine);
  assign digit_val = DigitW'(rx_byte_i - AsciiZero);

  assign speed_calc = SpeedW'(SpeedW'(digits_q[0]) * Weight1000)
                    + SpeedW'(SpeedW'(digits_q[1]) * Weight100)
                    + SpeedW'(SpeedW'(digits_q[2]) * Weight10)
                    + SpeedW'(digit_val);

  always_comb begin
    state_d = ST_IDLE;
    digits_d = digits_q;
    direction_d = direction_q;
    motor_on_d = motor_on_q;
    speed_d = speed_q;
    case (state_q)
      ST_D1: state_d = (rx_byte_i == "I") ? ST_D2 : ST_IDLE;
      ST_D2: state_d = (rx_byte_i == "R") ? ST_D3 : ST_IDLE;
      ST_D3: state_d = (rx_byte_i == AsciiColon) ? ST_D4 : ST_IDLE;
      ST_D4: state_d = (rx_byte_i == "C") ? ST_DC1 : ST_IDLE;
      ST_DC1: begin
        if (rx_byte_i == "W") begin
          direction_d = 1'b1;
        end else if (rx_byte_i == "C") begin
          state_d = ST_DC2;
        end
      end
      ST_DC2: begin
        if (rx_byte_i == "W") begin
          direction_d = 1'b0;
        end
      end
      ST_M1: state_d = (rx_byte_i == "O") ? ST_M2 : ST_IDLE;
      ST_M2: state_d = (rx_byte_i == "T") ? ST_M3 : ST_IDLE;
      ST_M3: state_d = (rx_byte_i == "O") ? ST_M4 : ST_IDLE;
      ST_M4: state_d = (rx_byte_i == "R") ? ST_M5 : ST_IDLE;
      ST_M5: state_d = (rx_byte_i == AsciiColon) ? ST_MO : ST_IDLE;
      ST_MO: state_d = (rx_byte_i == "O") ? ST_MF : ST_IDLE;
      ST_MF: begin
        if (rx_byte_i == "N") begin
          motor_on_d = 1'b1;
        end else if (rx_byte_i == "F") begin
          state_d = ST_MFF;
        end
      end
      ST_MFF: begin
        if (rx_byte_i == "F") begin
          motor_on_d = 1'b0;
        end
      end
      ST_R1: state_d = (rx_byte_i == "P") ? ST_R2 : ST_IDLE;
      ST_R2: state_d = (rx_byte_i == "M") ? ST_R3 : ST_IDLE;
      ST_R3: state_d = (rx_byte_i == AsciiColon) ? ST_RD0 : ST_IDLE;
      ST_RD0: begin
        if (is_digit) begin
          digits_d[0] = digit_val;
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        if (is_digit) begin
          digits_d[1] = digit_val;
          state_d = ST_RD2;
        end
      end
      ST_RD2: begin
        if (is_digit) begin
          digits_d[2] = digit_val;
          state_d = ST_RDOT;
        end
      end
      ST_RDOT: state_d = (rx_byte_i == AsciiDot) ? ST_RFRAC : ST_IDLE;
      ST_RFRAC: begin
        if (is_digit) begin
          speed_d = speed_calc;
        end
      end
      default: begin
        if (rx_byte_i == "D") begin
          state_d = ST_D1;
        end else if (rx_byte_i == "M") begin
          state_d = ST_M1;
        end else if (rx_byte_i == "R") begin
          state_d = ST_R1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      direction_q <= 1'b0;
      motor_on_q <= 1'b0;
      speed_q <= SpeedReset;
    end else if (step_i) begin
      state_q <= state_d;
      direction_q <= direction_d;
      motor_on_q <= motor_on_d;
      speed_q <= speed_d;
    end
  end

  // digit store needs no reset, always written before it is read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      digits_q <= digits_d;
    end
  end

  assign result_o.direction = direction_d;
  assign result_o.motor_on = motor_on_d;
  assign result_o.speed_tenths = speed_d;

endmodule

// File: hw/rtl/motor_command_text_parser.sv
// ----------------------------------------------------------------------------
// motor_command_text_parser
// Stream front end for the motor command recogniser: input beat register,
// parser, result register.
// ----------------------------------------------------------------------------
// path: input beat register, parser, result register; a stalled result holds the parser step
// throughput: one byte per cycle while m_tready_i does not stall the result beat
// reset: idle, direction 0, motor off, speed 110 (11.0 rpm)
`timescale 1ns / 1ps

module motor_command_text_parser
  import mcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,  // rx_byte[7:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o   // direction[0], motor_on[1], speed_tenths[15:2]
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  mcp_result_t out_q;
  mcp_result_t result;
  logic        step;

  assign step = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || step;

  mcp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .rx_byte_i(in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o = {out_q.speed_tenths, out_q.motor_on, out_q.direction};

endmodule

// File: test/tb_motor_command_text_parser.sv
// ----------------------------------------------------------------------------
// tb_motor_command_text_parser
// Self-checking bench for the motor command parser. A short directed table
// covers reset values, high-bit bytes and the extreme commands, then random
// command streams (well formed, corrupted and noise) run under three
// idling profiles. Every beat is checked against typed row values or
// a behavioural model of the parser held in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_motor_command_text_parser
  import mcp_pkg::*;
();

  localparam int unsigned NumRows = 25;
  localparam int unsigned NumCmdBytes = 1150;

  typedef struct packed {
    logic [7:0]  ch;
    logic        chk;
    mcp_result_t want;
  } cmd_row_t;

  // byte, typed check flag, {speed_tenths, motor_on, direction}
  localparam logic [24:0] CmdRows [NumRows] = '{
    {8'h00, 1'b1, 14'd110, 1'b0, 1'b0},
    {8'hff, 1'b1, 14'd110, 1'b0, 1'b0},
    {"R", 1'b0, 16'd0}, {"P", 1'b0, 16'd0}, {"M", 1'b0, 16'd0},
    {":", 1'b0, 16'd0}, {"9", 1'b0, 16'd0}, {"9", 1'b0, 16'd0},
    {"9", 1'b0, 16'd0}, {".", 1'b0, 16'd0},
    {"9", 1'b1, 14'd9999, 1'b0, 1'b0},
    {"D", 1'b0, 16'd0}, {"I", 1'b0, 16'd0}, {"R", 1'b0, 16'd0},
    {":", 1'b0, 16'd0}, {"C", 1'b0, 16'd0},
    {"W", 1'b1, 14'd9999, 1'b0, 1'b1},
    {"M", 1'b0, 16'd0}, {"O", 1'b0, 16'd0}, {"T", 1'b0, 16'd0},
    {"O", 1'b0, 16'd0}, {"R", 1'b0, 16'd0}, {":", 1'b0, 16'd0},
    {"O", 1'b0, 16'd0},
    {"N", 1'b1, 14'd9999, 1'b1, 1'b1}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [15:0] m_tdata_o;

  logic        row_chk;
  mcp_result_t row_want;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned bad_beats;

  mcp_result_t status_q [$];
  logic [7:0]  cmd_q [$];

  parse_state_e pst;
  logic [3:0]   dgt [NumIntDigits];
  logic         dir_q;
  logic         on_q;
  logic [13:0]  spd_q;

  motor_command_text_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= AsciiZero) && (c <= AsciiNine);
  endfunction

  function automatic parse_state_e match_or_idle(input logic [7:0] c, input logic [7:0] want,
                                                 input parse_state_e nxt);
    return (c == want) ? nxt : ST_IDLE;
  endfunction

  // one parser step on the bench copy of the state
  function automatic mcp_result_t step_parser(input logic [7:0] c);
    parse_state_e nxt;
    int           sum;
    mcp_result_t  res;
    nxt = ST_IDLE;
    case (pst)
      ST_D1:  nxt = match_or_idle(c, "I", ST_D2);
      ST_D2:  nxt = match_or_idle(c, "R", ST_D3);
      ST_D3:  nxt = match_or_idle(c, AsciiColon, ST_D4);
      ST_D4:  nxt = match_or_idle(c, "C", ST_DC1);
      ST_DC1: begin
        if (c == "W") dir_q = 1'b1;
        else if (c == "C") nxt = ST_DC2;
      end
      ST_DC2: begin
        if (c == "W") dir_q = 1'b0;
      end
      ST_M1:  nxt = match_or_idle(c, "O", ST_M2);
      ST_M2:  nxt = match_or_idle(c, "T", ST_M3);
      ST_M3:  nxt = match_or_idle(c, "O", ST_M4);
      ST_M4:  nxt = match_or_idle(c, "R", ST_M5);
      ST_M5:  nxt = match_or_idle(c, AsciiColon, ST_MO);
      ST_MO:  nxt = match_or_idle(c, "O", ST_MF);
      ST_MF: begin
        if (c == "N") on_q = 1'b1;
        else if (c == "F") nxt = ST_MFF;
      end
      ST_MFF: begin
        if (c == "F") on_q = 1'b0;
      end
      ST_R1:  nxt = match_or_idle(c, "P", ST_R2);
      ST_R2:  nxt = match_or_idle(c, "M", ST_R3);
      ST_R3:  nxt = match_or_idle(c, AsciiColon, ST_RD0);
      ST_RD0: begin
        if (is_digit(c)) begin
          dgt[0] = 4'(c - AsciiZero);
          nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        if (is_digit(c)) begin
          dgt[1] = 4'(c - AsciiZero);
          nxt = ST_RD2;
        end
      end
      ST_RD2: begin
        if (is_digit(c)) begin
          dgt[2] = 4'(c - AsciiZero);
          nxt = ST_RDOT;
        end
      end
      ST_RDOT: nxt = match_or_idle(c, AsciiDot, ST_RFRAC);
      ST_RFRAC: begin
        if (is_digit(c)) begin
          sum = int'(dgt[0]) * 1000 + int'(dgt[1]) * 100 + int'(dgt[2]) * 10
                + int'(c - AsciiZero);
          spd_q = 14'(sum);
        end
      end
      default: begin
        if (c == "D") nxt = ST_D1;
        else if (c == "M") nxt = ST_M1;
        else if (c == "R") nxt = ST_R1;
      end
    endcase
    pst = nxt;
    res.direction = dir_q;
    res.motor_on = on_q;
    res.speed_tenths = spd_q;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input mcp_result_t got,
                               input mcp_result_t want);
    bad_beats++;
    if (bad_beats <= 10) begin
      $display("mismatch (%s): expected dir %0b on %0b speed %0d, got dir %0b on %0b speed %0d",
               what, want.direction, want.motor_on, want.speed_tenths,
               got.direction, got.motor_on, got.speed_tenths);
    end
  endtask

  // prediction on input beats, checking on result beats, same edge
  always @(posedge clk_i) begin : scoreboard
    mcp_result_t pred;
    mcp_result_t got;
    mcp_result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        pred = step_parser(s_tdata_i);
        status_q.push_back(row_chk ? row_want : pred);
      end
      if (m_tvalid_o && m_tready_i) begin
        got = m_tdata_o;
        if (status_q.size() == 0) begin
          note_mismatch("unexpected beat", got, '0);
        end else begin
          want = status_q.pop_front();
          if (got.direction !== want.direction || got.motor_on !== want.motor_on ||
              got.speed_tenths !== want.speed_tenths) begin
            note_mismatch("status", got, want);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic chk, input mcp_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    row_chk <= chk;
    row_want <= want;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_all_status();
    s_tvalid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) cmd_q.push_back(s[i]);
  endfunction

  function automatic void push_rpm();
    int unsigned mode;
    mode = $urandom_range(0, 7);
    push_text("RPM:");
    for (int i = 0; i < 4; i++) begin
      if (i == 3) push_text(".");
      if (mode == 0) cmd_q.push_back(AsciiZero);
      else if (mode == 1) cmd_q.push_back(AsciiNine);
      else cmd_q.push_back(8'(AsciiZero + $urandom_range(0, 9)));
    end
  endfunction

  // fills cmd_q; returns 0 for pure noise, which does not count
  function automatic bit make_command();
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(0, 9);
    cmd_q.delete();
    if (kind == 9) begin
      for (int i = 0; i < $urandom_range(1, 4); i++) cmd_q.push_back(8'($urandom_range(0, 255)));
      return 1'b0;
    end
    case (kind % 5)
      0: push_text("DIR:CW");
      1: push_text("DIR:CCW");
      2: push_text("MOTOR:ON");
      3: push_text("MOTOR:OFF");
      default: push_rpm();
    endcase
    if (kind >= 6) begin
      // corrupt one character or cut the text after it, often the last
      pos = ($urandom_range(0, 1) == 0) ? cmd_q.size() - 1 : $urandom_range(0, cmd_q.size() - 1);
      case ($urandom_range(0, 3))
        0: cmd_q[pos] = 8'($urandom_range(0, 255));
        1: cmd_q[pos] = 8'($urandom_range(8'h20, 8'h5a));
        2: cmd_q[pos] = cmd_q[pos] ^ 8'h80;
        default: cmd_q = cmd_q[0:pos];
      endcase
    end
    return 1'b1;
  endfunction

  initial begin
    cmd_row_t    row;
    int unsigned sent;
    int unsigned phase;
    bit          counts;
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = 8'h00;
    row_chk = 1'b0;
    row_want = '0;
    tx_idle_pct = 37;
    rx_idle_pct = 45;
    bad_beats = 0;
    pst = ST_IDLE;
    for (int i = 0; i < NumIntDigits; i++) dgt[i] = '0;
    dir_q = 1'b0;
    on_q = 1'b0;
    spd_q = SpeedReset;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      row = CmdRows[i];
      send_byte(row.ch, row.chk, row.want);
    end

    sent = 0;
    phase = 0;
    while (sent < NumCmdBytes) begin
      if (phase == 0 && sent >= NumCmdBytes / 3) begin
        wait_all_status();
        tx_idle_pct = 45;
        rx_idle_pct = 37;
        phase = 1;
      end else if (phase == 1 && sent >= 2 * NumCmdBytes / 3) begin
        wait_all_status();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase = 2;
      end
      counts = make_command();
      foreach (cmd_q[i]) send_byte(cmd_q[i], 1'b0, '0);
      if (counts) sent += cmd_q.size();
    end

    wait_all_status();
    repeat (8) @(negedge clk_i);
    if (bad_beats == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
